/* rtl/isel_pkg.sv */
// Package with the constants and transaction types of the interval scheduling selector.
package isel_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int RESULT_CAP = 64;
  localparam int NSEL_W     = $clog2(RESULT_CAP + 1);
  localparam int START_W    = 16;
  localparam int RUN_W      = 16;
  localparam int END_W      = 17;
  localparam int INDEX_W    = 6;

  typedef struct packed {
    logic [START_W-1:0] start_time;
    logic [RUN_W-1:0]   run_length;
    logic               is_final;
  } item_t;

  typedef struct packed {
    logic [START_W-1:0] sel_start;
    logic [END_W-1:0]   sel_end;
    logic [INDEX_W-1:0] sel_index;
    logic               last_result;
    logic               overflowed;
  } result_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [END_W-1:0]   finish;
  } entry_t;

endpackage

/* rtl/isel_out_reg.sv */
// Output register that holds one result transaction until the receiver takes it.
module isel_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  isel_pkg::result_t push_data,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output isel_pkg::result_t result
);
  import isel_pkg::*;

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result <= push_data;
    end
  end

endmodule

/* rtl/interval_scheduling_selector_top.sv */
// Interval scheduling selector: sorted interval store and greedy earliest-finish selection.
// An interval is taken in the idle state; the shift state then moves up, one per step, each
// stored entry with a later end, in an insertion loop over the store's read and write ports.
// A final transaction then scans the store with a read state and an evaluate state per
// stored interval, then a read state that detects the end and a flush state; results leave
// through an output register, one per cycle at most.
// Reset is synchronous; the store contents are not cleared and need no clearing pass.
module interval_scheduling_selector_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  isel_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output isel_pkg::result_t result
);
  import isel_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_SEL_RD = 3'd2;
  localparam logic [2:0] S_SEL_EV = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  entry_t mem [MAX_ITEMS];
  entry_t rd_data;
  entry_t wr_data;
  logic   rd_en;
  logic   wr_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              ovf, ovf_next;
  logic [END_W-1:0]  last_end, last_end_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [CNT_W-1:0]  scan, scan_next;
  logic [NSEL_W-1:0] nsel, nsel_next;
  entry_t            new_ent, new_ent_next;
  logic              fin, fin_next;
  result_t           pend, pend_next;
  logic              pend_v, pend_v_next;

  logic              push;
  result_t           push_data;
  logic              free;
  logic [END_W-1:0]  item_end;

  assign item_end = {1'b0, item.start_time} + {1'b0, item.run_length};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_next      = ovf;
    last_end_next = last_end;
    pos_next      = pos;
    scan_next     = scan;
    nsel_next     = nsel;
    new_ent_next  = new_ent;
    fin_next      = fin;
    pend_next     = pend;
    pend_v_next   = pend_v;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = new_ent;
    push          = 1'b0;
    push_data     = pend;
    item_stall    = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            new_ent_next = '{start: item.start_time, finish: item_end};
            pos_next     = count[ADDR_W-1:0];
            fin_next     = item.is_final;
            rd_en        = 1'b1;
            rd_addr      = count[ADDR_W-1:0] - ADDR_W'(1);
            state_next   = S_SHIFT;
          end else begin
            ovf_next = 1'b1;
            if (item.is_final) begin
              scan_next  = '0;
              nsel_next  = '0;
              state_next = S_SEL_RD;
            end
          end
        end
      end
      S_SHIFT: begin
        wr_en = 1'b1;
        if (pos == '0 || !(rd_data.finish > new_ent.finish)) begin
          count_next = count + CNT_W'(1);
          if (fin) begin
            scan_next  = '0;
            nsel_next  = '0;
            state_next = S_SEL_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          wr_data  = rd_data;
          pos_next = pos - ADDR_W'(1);
          rd_en    = 1'b1;
          rd_addr  = pos - ADDR_W'(2);
        end
      end
      S_SEL_RD: begin
        if (scan == count) begin
          state_next = S_FLUSH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = scan[ADDR_W-1:0];
          scan_next  = scan + CNT_W'(1);
          state_next = S_SEL_EV;
        end
      end
      S_SEL_EV: begin
        if (nsel == '0 || {1'b0, rd_data.start} >= last_end) begin
          if (!pend_v || free) begin
            push          = pend_v;
            pend_next     = '{sel_start: rd_data.start, sel_end: rd_data.finish,
                              sel_index: nsel[INDEX_W-1:0], last_result: 1'b0,
                              overflowed: ovf};
            pend_v_next   = 1'b1;
            nsel_next     = nsel + NSEL_W'(1);
            last_end_next = rd_data.finish;
            state_next    = (nsel == NSEL_W'(RESULT_CAP - 1)) ? S_FLUSH : S_SEL_RD;
          end
        end else begin
          state_next = S_SEL_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_v || free) begin
          push                  = pend_v;
          push_data.last_result = 1'b1;
          pend_v_next           = 1'b0;
          count_next            = '0;
          ovf_next              = 1'b0;
          state_next            = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      last_end <= '0;
      pend_v   <= 1'b0;
      scan     <= '0;
      nsel     <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf      <= ovf_next;
      last_end <= last_end_next;
      pend_v   <= pend_v_next;
      scan     <= scan_next;
      nsel     <= nsel_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    new_ent <= new_ent_next;
    fin     <= fin_next;
    pend    <= pend_next;
  end

  isel_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
